// File: src/ggt_pkg.sv
package ggt_pkg;

  // Field and block geometry
  localparam int HALF_W    = 64;
  localparam int BLK_W     = 2 * HALF_W;
  localparam int BYTE_W    = 8;
  localparam int BLK_BYTES = BLK_W / BYTE_W;
  localparam int VB_W      = 5;

  // Multiplier digit: bits of the left operand consumed per cycle
  localparam int DIGIT_W   = 8;
  localparam int MUL_STEPS = BLK_W / DIGIT_W;
  localparam int STEP_W    = $clog2(MUL_STEPS);

  // Reflected reduction constant, applied to the top byte
  localparam logic [BYTE_W-1:0] RED_POLY = 8'hE1;

  localparam int COUNT_BITS_DEF = 36;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HI  = 2'd0,
    CFG_KEY_LO  = 2'd1,
    CFG_MASK_HI = 2'd2,
    CFG_MASK_LO = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

// File: src/ggt_in_if.sv
interface ggt_in_if
  import ggt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] block_high;
  logic [HALF_W-1:0] block_low;
  logic [VB_W-1:0]   valid_bytes;
  logic              last;

  modport source (output valid, block_high, block_low, valid_bytes, last, input ready);
  modport sink   (input valid, block_high, block_low, valid_bytes, last, output ready);
endinterface

// File: src/ggt_out_if.sv
interface ggt_out_if
  import ggt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] tag_high;
  logic [HALF_W-1:0] tag_low;

  modport source (output valid, tag_high, tag_low, input ready);
  modport sink   (input valid, tag_high, tag_low, output ready);
endinterface

// File: src/ggt_cfg_if.sv
interface ggt_cfg_if
  import ggt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [HALF_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/ggt_gfmul.sv
module ggt_gfmul
  import ggt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [BLK_W-1:0] x_in,
  input  logic [BLK_W-1:0] h_in,
  output logic [BLK_W-1:0] z_out,
  output mul_status_t      status
);

  logic [BLK_W-1:0]  x_r, v_r, z_r;
  logic [BLK_W-1:0]  v_nxt, z_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic              run_r, done_r;

  // One digit of x per cycle, most significant bit of the digit first
  always_comb begin
    logic [BLK_W-1:0] zt;
    logic [BLK_W-1:0] vt;
    logic             carry;
    zt = z_r;
    vt = v_r;
    for (int j = 0; j < DIGIT_W; j++) begin
      if (x_r[BLK_W-1-j]) begin
        zt = zt ^ vt;
      end
      carry = vt[0];
      vt = vt >> 1;
      if (carry) begin
        vt[BLK_W-1 -: BYTE_W] = vt[BLK_W-1 -: BYTE_W] ^ RED_POLY;
      end
    end
    z_nxt = zt;
    v_nxt = vt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == STEP_W'(MUL_STEPS - 1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(MUL_STEPS - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_in;
      v_r <= h_in;
      z_r <= '0;
    end else if (run_r) begin
      x_r <= x_r << DIGIT_W;
      v_r <= v_nxt;
      z_r <= z_nxt;
    end
  end

  assign z_out       = z_r;
  assign status.busy = run_r;
  assign status.done = done_r;

endmodule

// File: src/ggt_len_cnt.sv
module ggt_len_cnt
  import ggt_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic                  add_en,
  input  logic [VB_W-1:0]       add_bytes,
  output logic [COUNT_BITS-1:0] count
);

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS:0]   sum;

  // Saturate at all ones
  always_comb begin
    sum = {1'b0, count_r} + (COUNT_BITS + 1)'(add_bytes);
    count_nxt = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (clr) begin
      count_r <= '0;
    end else if (add_en) begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

// File: src/gcm_ghash_tag.sv
// A non-last block holds ready low from its transfer until its multiply is done; a last
// block gives its tag after its data fold and the length fold (only the length fold for an
// empty last block). A new block waits for the 16-step 8-bit digit-serial GF multiplier.
// Reset (rst_n low, synchronous): clears keys, mask, GHASH accumulator, byte count and
// the output valid; ready holds high from reset, so a block may transfer right after it.
module gcm_ghash_tag
  import ggt_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  ggt_in_if.sink  in_ch,
  ggt_out_if.source out_ch,
  ggt_cfg_if.sink cfg_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BLK_WAIT,
    S_LEN_WAIT,
    S_PUT
  } state_t;

  state_t state_r, state_nxt;

  // Configuration: hash key H and the final mask AES_K(J0)
  logic [BLK_W-1:0] key_r, mask_r;

  // Running GHASH value and output register
  logic [BLK_W-1:0] acc_r, acc_nxt;
  logic [BLK_W-1:0] tag_r, tag_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_r, last_nxt;

  logic [VB_W-1:0]       vb_clamp;
  logic [BLK_W-1:0]      blk_in;
  logic [BLK_W-1:0]      blk_masked;
  logic [BLK_W-1:0]      len_blk;
  logic [COUNT_BITS-1:0] count;
  logic                  in_xfer;
  logic                  out_free;
  logic                  cnt_clr;

  logic             mul_start;
  logic [BLK_W-1:0] mul_x;
  logic [BLK_W-1:0] mul_z;
  mul_status_t      mul_st;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      mask_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_KEY_HI:  key_r[BLK_W-1 -: HALF_W]  <= cfg_ch.data;
        CFG_KEY_LO:  key_r[HALF_W-1:0]         <= cfg_ch.data;
        CFG_MASK_HI: mask_r[BLK_W-1 -: HALF_W] <= cfg_ch.data;
        CFG_MASK_LO: mask_r[HALF_W-1:0]        <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Take a new block only when the multiplier is free; a finished tag may still wait
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign blk_in = {in_ch.block_high, in_ch.block_low};

  // Clamp byte count to a full block and zero the unused tail bytes
  always_comb begin
    vb_clamp = in_ch.valid_bytes[VB_W-1] ? VB_W'(BLK_BYTES) : in_ch.valid_bytes;
    for (int k = 0; k < BLK_BYTES; k++) begin
      blk_masked[BLK_W-1-BYTE_W*k -: BYTE_W] =
        (VB_W'(k) < vb_clamp) ? blk_in[BLK_W-1-BYTE_W*k -: BYTE_W] : '0;
    end
  end

  // Length block: zero upper half, message length in bits in the lower half
  assign len_blk = {{HALF_W{1'b0}}, HALF_W'({count, 3'b000})};

  // Control and operand select for the multiplier
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    tag_nxt       = tag_r;
    out_valid_nxt = out_valid_r;
    last_nxt      = last_r;
    mul_start     = 1'b0;
    mul_x         = acc_r ^ blk_masked;
    cnt_clr       = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          last_nxt = in_ch.last;
          if (vb_clamp != '0) begin
            // fold the data block first
            mul_start = 1'b1;
            mul_x     = acc_r ^ blk_masked;
            state_nxt = S_BLK_WAIT;
          end else if (in_ch.last) begin
            // empty final block: skip straight to the length fold
            mul_start = 1'b1;
            mul_x     = acc_r ^ len_blk;
            state_nxt = S_LEN_WAIT;
          end
        end
      end
      S_BLK_WAIT: begin
        if (mul_st.done) begin
          acc_nxt = mul_z;
          if (last_r) begin
            mul_start = 1'b1;
            mul_x     = mul_z ^ len_blk;
            state_nxt = S_LEN_WAIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LEN_WAIT: begin
        if (mul_st.done) begin
          acc_nxt   = mul_z;
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        // hold until the output register can take the tag, then clear for the next message
        if (out_free) begin
          tag_nxt       = acc_r ^ mask_r;
          out_valid_nxt = 1'b1;
          acc_nxt       = '0;
          cnt_clr       = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      last_r      <= last_nxt;
    end
    tag_r <= tag_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tag_high = tag_r[BLK_W-1 -: HALF_W];
  assign out_ch.tag_low  = tag_r[HALF_W-1:0];

  ggt_gfmul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .x_in   (mul_x),
    .h_in   (key_r),
    .z_out  (mul_z),
    .status (mul_st)
  );

  ggt_len_cnt #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cnt (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cnt_clr),
    .add_en    (in_xfer),
    .add_bytes (vb_clamp),
    .count     (count)
  );

  // A block transfer never lands while a multiply is in flight
  a_no_xfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !mul_st.busy)
    else $error("block transfer while multiplier busy");

  // Multiplier completion is only seen in a waiting state
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_st.done |-> (state_r == S_BLK_WAIT || state_r == S_LEN_WAIT))
    else $error("multiplier done outside a wait state");

  // Loading a tag clears accumulator and byte count for the next message
  a_clear_on_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT && out_free) |=> (acc_r == '0 && count == '0 && out_valid_r))
    else $error("message state not cleared after tag");

endmodule
